/* hdl/key_debounce_press_classifier_macros.svh */
// Assertion macros for the key debounce / press classifier.
// Needs signals clk and rst in the scope that uses them.
// Empty when SYNTHESIS is defined.
`ifndef KEY_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH
`define KEY_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every edge outside reset.
`define KDPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define KDPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define KDPC_ASSERT(lbl, prop, msg)
`define KDPC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* hdl/kdpc_pkg.sv */
// Package for the key debounce / press classifier.
// Action codes, register indexes and register reset values. No dependencies.
package kdpc_pkg;

  localparam int unsigned TimeWidth = 32;
  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned CfgIdxWidth = 2;

  typedef enum logic [1:0] {
    ACT_IDLE    = 2'd0,
    ACT_HOLDING = 2'd1,
    ACT_SHORT   = 2'd2,
    ACT_LONG    = 2'd3
  } action_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_SHORT_MIN = 2'd1,
    REG_SHORT_MAX = 2'd2,
    REG_LONG_MIN  = 2'd3
  } reg_idx_t;

  localparam logic [CfgWidth-1:0] DebounceRst = 16'd200;
  localparam logic [CfgWidth-1:0] ShortMinRst = 16'd150;
  localparam logic [CfgWidth-1:0] ShortMaxRst = 16'd1000;
  localparam logic [CfgWidth-1:0] LongMinRst  = 16'd1500;

endpackage

/* hdl/key_debounce_press_classifier.sv */
// Key debounce and short/long press classifier: one scan item in, one action out.
// Each action passes the input register, then the result queue, before it is valid.
// Throughput: one item per cycle; input stalls only with both queue entries full.
// Reset (rst, synchronous, active high): registers back to 200/150/1000/1500 ms,
// key released, no press in progress, input register and result queue empty.
// Uses kdpc_pkg and macros.
`include "key_debounce_press_classifier_macros.svh"

module key_debounce_press_classifier
  import kdpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // scan items
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   key_level,
  input  logic [TimeWidth-1:0]   time_now_ms,
  // actions
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             action,
  // register writes
  input  logic                   cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]    cfg_wdata
);

  // Press phase. NOPRESS is both the reset phase and the phase after a report.
  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_HOLDING  = 2'd2,
    PH_NOPRESS  = 2'd3
  } phase_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CfgWidth-1:0] debounce_ms;
  logic [CfgWidth-1:0] short_min_ms;
  logic [CfgWidth-1:0] short_max_ms;
  logic [CfgWidth-1:0] long_min_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms  <= DebounceRst;
      short_min_ms <= ShortMinRst;
      short_max_ms <= ShortMaxRst;
      long_min_ms  <= LongMinRst;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEBOUNCE:  debounce_ms  <= cfg_wdata;
        REG_SHORT_MIN: short_min_ms <= cfg_wdata;
        REG_SHORT_MAX: short_max_ms <= cfg_wdata;
        REG_LONG_MIN:  long_min_ms  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. It takes a new item whenever the classifier stage can
  // retire the one it holds, so items flow one per cycle.
  // ---------------------------------------------------------------------------
  logic                 in_reg_valid;
  logic                 in_reg_level;
  logic [TimeWidth-1:0] in_reg_time;

  logic [1:0] q_count;     // 0..2 actions waiting
  logic       q_full;
  logic       proc_fire;   // classifier consumes the input register
  logic       in_fire;

  assign q_full    = (q_count == 2'd2);
  assign in_stall  = in_reg_valid && q_full;
  assign in_fire   = in_valid && !in_stall;
  assign proc_fire = in_reg_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_fire) begin
      in_reg_valid <= 1'b1;
    end else if (proc_fire) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_reg_level <= key_level;
      in_reg_time  <= time_now_ms;
    end
  end

  // ---------------------------------------------------------------------------
  // Classifier state and single-pass update
  // ---------------------------------------------------------------------------
  logic                 stable_level;
  logic [TimeWidth-1:0] last_change_time;
  logic [TimeWidth-1:0] press_start_time;
  logic [TimeWidth-1:0] hold_time;
  phase_t               press_phase;
  logic                 long_latched;

  logic                 stable_level_next;
  logic [TimeWidth-1:0] last_change_time_next;
  logic [TimeWidth-1:0] press_start_time_next;
  logic [TimeWidth-1:0] hold_time_next;
  phase_t               press_phase_next;
  logic                 long_latched_next;
  action_t              act;

  logic [TimeWidth-1:0] since_change;  // wraps mod 2^32
  logic [TimeWidth-1:0] hold_now;      // wraps mod 2^32
  logic                 debounce_ok;

  assign since_change = in_reg_time - last_change_time;
  assign hold_now     = in_reg_time - press_start_time;
  assign debounce_ok  = (since_change >= TimeWidth'(debounce_ms));

  always_comb begin
    stable_level_next     = stable_level;
    last_change_time_next = last_change_time;
    press_start_time_next = press_start_time;
    hold_time_next        = hold_time;
    press_phase_next      = press_phase;
    long_latched_next     = long_latched;
    act                   = ACT_IDLE;

    // Level tracking. A change inside the debounce window leaves all state alone.
    if (in_reg_level != stable_level) begin
      if (debounce_ok) begin
        last_change_time_next = in_reg_time;
        stable_level_next     = in_reg_level;
        if (!in_reg_level) begin
          press_phase_next      = PH_PRESSED;
          press_start_time_next = in_reg_time;
        end else begin
          long_latched_next = 1'b0;
          press_phase_next  = PH_RELEASED;
          hold_time_next    = hold_now;
        end
      end
    end else if (!in_reg_level) begin
      // Still pressed: track hold unless a long press already fired.
      if (!long_latched) begin
        press_phase_next = PH_HOLDING;
        hold_time_next   = hold_now;
      end
    end else begin
      press_phase_next = PH_NOPRESS;
    end

    // Classify on the updated phase and hold time.
    if (press_phase_next == PH_HOLDING) begin
      if (hold_time_next >= TimeWidth'(long_min_ms)) begin
        press_start_time_next = '0;
        hold_time_next        = '0;
        press_phase_next      = PH_NOPRESS;
        long_latched_next     = 1'b1;
        act                   = ACT_LONG;
      end else begin
        act = ACT_HOLDING;
      end
    end else if (press_phase_next == PH_RELEASED &&
                 hold_time_next >= TimeWidth'(short_min_ms) &&
                 hold_time_next <= TimeWidth'(short_max_ms)) begin
      press_start_time_next = '0;
      hold_time_next        = '0;
      press_phase_next      = PH_NOPRESS;
      act                   = ACT_SHORT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level     <= 1'b1;
      last_change_time <= '0;
      press_start_time <= '0;
      hold_time        <= '0;
      press_phase      <= PH_NOPRESS;
      long_latched     <= 1'b0;
    end else if (proc_fire) begin
      stable_level     <= stable_level_next;
      last_change_time <= last_change_time_next;
      press_start_time <= press_start_time_next;
      hold_time        <= hold_time_next;
      press_phase      <= press_phase_next;
      long_latched     <= long_latched_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: two entries, so the input side can still move after the
  // consumer starts stalling, until both entries are full.
  // ---------------------------------------------------------------------------
  logic [1:0] q_mem [2];
  logic       q_wr_ptr;
  logic       q_rd_ptr;
  logic       out_fire;

  assign out_valid = (q_count != 2'd0);
  assign out_fire  = out_valid && !out_stall;
  assign action    = q_mem[q_rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count  <= 2'd0;
      q_wr_ptr <= 1'b0;
      q_rd_ptr <= 1'b0;
    end else begin
      if (proc_fire) begin
        q_wr_ptr <= ~q_wr_ptr;
      end
      if (out_fire) begin
        q_rd_ptr <= ~q_rd_ptr;
      end
      if (proc_fire && !out_fire) begin
        q_count <= q_count + 2'd1;
      end else if (out_fire && !proc_fire) begin
        q_count <= q_count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      q_mem[q_wr_ptr] <= act;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `KDPC_ASSERT(a_q_bound, q_count <= 2'd2, "result queue count above two")
  `KDPC_ASSERT(a_latch_consistent,
               long_latched |-> (press_phase == PH_NOPRESS && !stable_level),
               "long latch set without a held key in no-press phase")
  `KDPC_ASSERT(a_pressed_level,
               (press_phase == PH_PRESSED || press_phase == PH_HOLDING) |-> !stable_level,
               "press phase while stable level is released")
  `KDPC_ASSERT(a_long_latches,
               (proc_fire && act == ACT_LONG) |=> long_latched,
               "long press reported without latching")

endmodule
